// ----- hdl/cbr_pkg.sv -----
// cbr_pkg: shared types, codes and helpers for the conv2d batch-norm relu unit
// no dependencies

package cbr_pkg;

    localparam int IN_CHANNELS_DEF  = 4;
    localparam int OUT_CHANNELS_DEF = 8;
    localparam int MAX_HEIGHT_DEF   = 32;
    localparam int MAX_WIDTH_DEF    = 32;
    localparam int KERNEL_SIZE_DEF  = 3;

    // signed row/column coordinate and clamped image dimension widths
    localparam int RC_W  = 10;
    localparam int DIM_W = 9;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    localparam logic [2:0] REG_STRIDE  = 3'd0;
    localparam logic [2:0] REG_PAD     = 3'd1;
    localparam logic [2:0] REG_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_WIDTH   = 3'd3;
    localparam logic [2:0] REG_EPSILON = 3'd4;

    typedef enum logic [2:0] {
        CMD_PIXEL    = 3'd0,
        CMD_WEIGHT   = 3'd1,
        CMD_BIAS     = 3'd2,
        CMD_GAMMA    = 3'd3,
        CMD_BETA     = 3'd4,
        CMD_MEAN     = 3'd5,
        CMD_VARIANCE = 3'd6,
        CMD_COMPUTE  = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [2:0]         out_chan;
        logic [1:0]         in_chan;
        logic [4:0]         row_index;
        logic [4:0]         col_index;
        logic [1:0]         tap_row;
        logic [1:0]         tap_col;
        logic signed [31:0] load_value;
    } t_item;

    typedef struct packed {
        logic [1:0]  stride_step;
        logic [1:0]  pad_amount;
        logic [5:0]  image_height;
        logic [5:0]  image_width;
        logic [15:0] norm_epsilon;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CONV,
        BK_GAIN,
        BK_SCALE,
        BK_MIX,
        BK_SHIFT,
        BK_OUT
    } t_back_state;

    typedef enum logic [1:0] {
        NM_IDLE,
        NM_ROOT,
        NM_DIV,
        NM_DONE
    } t_norm_state;

    function automatic logic [1:0] eff_stride(input logic [1:0] s);
        return (s == 2'd0) ? 2'd1 : s;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [5:0] v, input int maxv);
        logic [DIM_W-1:0] r;
        if (v == 6'd0) begin
            r = DIM_W'(1);
        end else if (int'(v) > maxv) begin
            r = DIM_W'(maxv);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- hdl/conv2d_batchnorm_relu_unit.sv -----
// conv2d_batchnorm_relu_unit: top level with config registers, front, queue and back
// depends on cbr_pkg, cbr_front, cbr_queue, cbr_back

// Load beats (pixel, weight, bias and batch-norm values) are taken one per cycle while
// the queue has room, and retire straight into the stores while the back end is idle.
// In a compute beat the tap walk (one image and kernel memory read per tap) runs
// alongside the normalizer, whose 24-step square root and 33-step reciprocal set the
// compute time at the default sizes. The front register and a two-entry queue keep
// accepting beats while a compute runs or a result waits.
// Stores come up undefined and need no clearing after reset.

module conv2d_batchnorm_relu_unit #(
    parameter int IN_CHANNELS  = cbr_pkg::IN_CHANNELS_DEF,
    parameter int OUT_CHANNELS = cbr_pkg::OUT_CHANNELS_DEF,
    parameter int MAX_HEIGHT   = cbr_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH    = cbr_pkg::MAX_WIDTH_DEF,
    parameter int KERNEL_SIZE  = cbr_pkg::KERNEL_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [2:0]  i_out_chan,
    input  logic [1:0]  i_in_chan,
    input  logic [4:0]  i_row_index,
    input  logic [4:0]  i_col_index,
    input  logic [1:0]  i_tap_row,
    input  logic [1:0]  i_tap_col,
    input  logic signed [31:0] i_load_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [14:0] o_result_value,
    output logic [2:0]  o_result_chan,
    output logic [4:0]  o_result_row,
    output logic [4:0]  o_result_col
);
    import cbr_pkg::*;

    logic [1:0]  r_stride;
    logic [1:0]  r_pad;
    logic [5:0]  r_height;
    logic [5:0]  r_width;
    logic [15:0] r_eps;
    logic        cfg_wr;
    t_cfg        cfg;
    t_item       in_item;
    t_item       q_in;
    t_item       q_head;
    logic        q_push;
    logic        q_pop;
    t_q_stat     q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= 2'd1;
            r_pad    <= 2'd1;
            r_height <= 6'd32;
            r_width  <= 6'd32;
            r_eps    <= 16'd1;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_STRIDE:  r_stride <= pwdata[1:0];
                REG_PAD:     r_pad    <= pwdata[1:0];
                REG_HEIGHT:  r_height <= pwdata[5:0];
                REG_WIDTH:   r_width  <= pwdata[5:0];
                REG_EPSILON: r_eps    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_STRIDE:  prdata = {30'd0, r_stride};
            REG_PAD:     prdata = {30'd0, r_pad};
            REG_HEIGHT:  prdata = {26'd0, r_height};
            REG_WIDTH:   prdata = {26'd0, r_width};
            REG_EPSILON: prdata = {16'd0, r_eps};
            default:     prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.stride_step    = r_stride;
        cfg.pad_amount     = r_pad;
        cfg.image_height   = r_height;
        cfg.image_width    = r_width;
        cfg.norm_epsilon   = r_eps;
        in_item.cmd        = t_cmd'(i_command);
        in_item.out_chan   = i_out_chan;
        in_item.in_chan    = i_in_chan;
        in_item.row_index  = i_row_index;
        in_item.col_index  = i_col_index;
        in_item.tap_row    = i_tap_row;
        in_item.tap_col    = i_tap_col;
        in_item.load_value = i_load_value;
    end

    cbr_front #(
        .IN_CHANNELS  (IN_CHANNELS),
        .OUT_CHANNELS (OUT_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH),
        .KERNEL_SIZE  (KERNEL_SIZE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (in_item),
        .o_push   (q_push),
        .o_item   (q_in),
        .i_q_stat (q_stat)
    );

    cbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    cbr_back #(
        .IN_CHANNELS  (IN_CHANNELS),
        .OUT_CHANNELS (OUT_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH),
        .KERNEL_SIZE  (KERNEL_SIZE)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_head         (q_head),
        .i_q_stat       (q_stat),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_value (o_result_value),
        .o_result_chan  (o_result_chan),
        .o_result_row   (o_result_row),
        .o_result_col   (o_result_col)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("handshake active right after reset");
`endif

endmodule

// ----- hdl/cbr_front.sv -----
// cbr_front: accepts command beats, range-checks them and forwards kept ones
// depends on cbr_pkg

module cbr_front #(
    parameter int IN_CHANNELS  = cbr_pkg::IN_CHANNELS_DEF,
    parameter int OUT_CHANNELS = cbr_pkg::OUT_CHANNELS_DEF,
    parameter int MAX_HEIGHT   = cbr_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH    = cbr_pkg::MAX_WIDTH_DEF,
    parameter int KERNEL_SIZE  = cbr_pkg::KERNEL_SIZE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbr_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  cbr_pkg::t_item  i_item,
    output logic            o_push,
    output cbr_pkg::t_item  o_item,
    input  cbr_pkg::t_q_stat i_q_stat
);
    import cbr_pkg::*;

    logic             r_valid;
    logic             r_keep;
    t_item            r_item;
    logic             keep;
    logic             drain;
    logic [1:0]       s;
    logic [RC_W-1:0]  full_h;
    logic [RC_W-1:0]  full_w;
    logic             oc_ok;
    logic             ic_ok;
    logic             comp_ok;

    always_comb begin
        s      = eff_stride(i_cfg.stride_step);
        full_h = RC_W'(clamp_dim(i_cfg.image_height, MAX_HEIGHT)) + RC_W'({i_cfg.pad_amount, 1'b0});
        full_w = RC_W'(clamp_dim(i_cfg.image_width, MAX_WIDTH)) + RC_W'({i_cfg.pad_amount, 1'b0});
        oc_ok  = int'(i_item.out_chan) < OUT_CHANNELS;
        ic_ok  = int'(i_item.in_chan) < IN_CHANNELS;
        comp_ok = oc_ok
                  && (int'(full_h) >= KERNEL_SIZE) && (int'(full_w) >= KERNEL_SIZE)
                  && (int'(RC_W'(i_item.row_index) * RC_W'(s)) <= int'(full_h) - KERNEL_SIZE)
                  && (int'(RC_W'(i_item.col_index) * RC_W'(s)) <= int'(full_w) - KERNEL_SIZE);
        unique case (i_item.cmd)
            CMD_PIXEL: begin
                keep = ic_ok && (int'(i_item.row_index) < MAX_HEIGHT)
                       && (int'(i_item.col_index) < MAX_WIDTH);
            end
            CMD_WEIGHT: begin
                keep = oc_ok && ic_ok && (int'(i_item.tap_row) < KERNEL_SIZE)
                       && (int'(i_item.tap_col) < KERNEL_SIZE);
            end
            CMD_COMPUTE: keep = comp_ok;
            default:     keep = oc_ok;
        endcase
    end

    assign drain   = r_valid && (!r_keep || !i_q_stat.full);
    assign o_ready = !r_valid || drain;
    assign o_push  = r_valid && r_keep && !i_q_stat.full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_keep  <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
            r_keep  <= keep;
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- hdl/cbr_queue.sv -----
// cbr_queue: short command queue between front and back
// depends on cbr_pkg

module cbr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cbr_pkg::t_item   i_item,
    input  logic             i_pop,
    output cbr_pkg::t_item   o_head,
    output cbr_pkg::t_q_stat o_stat
);
    import cbr_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ----- hdl/cbr_norm.sv -----
// cbr_norm: iterative square root and reciprocal giving 1/sqrt(var+eps) in Q16.16
// depends on cbr_pkg

module cbr_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_variance,
    input  logic [15:0]        i_epsilon,
    output logic               o_done,
    output logic [30:0]        o_inv
);
    import cbr_pkg::*;

    t_norm_state r_state;
    t_norm_state n_state;
    logic [47:0] r_rad;
    logic [25:0] r_rem;
    logic [23:0] r_root;
    logic [24:0] r_drem;
    logic [32:0] r_quo;
    logic [5:0]  r_cnt;

    logic signed [33:0] var_sum;
    logic [30:0]        var_clamp;
    logic [26:0]        rem_sh;
    logic [26:0]        trial;
    logic [24:0]        dsh;
    logic               nbit;

    always_comb begin
        var_sum = 34'(i_variance) + 34'(i_epsilon);
        if (var_sum < 0) begin
            var_clamp = '0;
        end else if (var_sum > 34'sh7FFFFFFF) begin
            var_clamp = 31'h7FFFFFFF;
        end else begin
            var_clamp = var_sum[30:0];
        end
        rem_sh = {r_rem[24:0], r_rad[47:46]};
        trial  = {1'b0, r_root, 2'b01};
        nbit   = (r_cnt == 6'd0);
        dsh    = {r_drem[23:0], nbit};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            NM_IDLE: if (i_start) n_state = NM_ROOT;
            NM_ROOT: begin
                if (r_cnt == 6'd23) begin
                    n_state = NM_DIV;
                end
            end
            NM_DIV: begin
                if (r_root == '0 || r_cnt == 6'd32) begin
                    n_state = NM_DONE;
                end
            end
            NM_DONE: if (i_start) n_state = NM_ROOT;
            default: n_state = NM_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == NM_DONE);
        o_inv  = (r_quo > 33'h07FFFFFFF) ? 31'h7FFFFFFF : r_quo[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NM_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_start || (r_state == NM_ROOT && r_cnt == 6'd23)) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {1'b0, var_clamp, 16'h0000};
            r_rem  <= '0;
            r_root <= '0;
            r_drem <= '0;
            r_quo  <= '0;
        end else if (r_state == NM_ROOT) begin
            r_rad <= {r_rad[45:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= 26'(rem_sh - trial);
                r_root <= {r_root[22:0], 1'b1};
            end else begin
                r_rem  <= 26'(rem_sh);
                r_root <= {r_root[22:0], 1'b0};
            end
        end else if (r_state == NM_DIV) begin
            if (r_root == '0) begin
                r_quo <= 33'h07FFFFFFF;
            end else if (dsh >= {1'b0, r_root}) begin
                r_drem <= dsh - {1'b0, r_root};
                r_quo  <= {r_quo[31:0], 1'b1};
            end else begin
                r_drem <= dsh;
                r_quo  <= {r_quo[31:0], 1'b0};
            end
        end
    end

endmodule

// ----- hdl/cbr_back.sv -----
// cbr_back: executes loads into the stores and runs the convolution, norm and relu
// depends on cbr_pkg and cbr_norm

module cbr_back #(
    parameter int IN_CHANNELS  = cbr_pkg::IN_CHANNELS_DEF,
    parameter int OUT_CHANNELS = cbr_pkg::OUT_CHANNELS_DEF,
    parameter int MAX_HEIGHT   = cbr_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH    = cbr_pkg::MAX_WIDTH_DEF,
    parameter int KERNEL_SIZE  = cbr_pkg::KERNEL_SIZE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cbr_pkg::t_cfg    i_cfg,
    input  cbr_pkg::t_item   i_head,
    input  cbr_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [14:0]      o_result_value,
    output logic [2:0]       o_result_chan,
    output logic [4:0]       o_result_row,
    output logic [4:0]       o_result_col
);
    import cbr_pkg::*;

    localparam int IMG_DEPTH = IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int TAPS      = IN_CHANNELS * KERNEL_SIZE * KERNEL_SIZE;
    localparam int KER_DEPTH = OUT_CHANNELS * TAPS;
    localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
    localparam int OC_W      = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int IC_W      = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
    localparam int K_W       = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
    localparam int ACC_W     = 34 + $clog2(TAPS + 1);

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh7FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sh80000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic signed [15:0] image_mem  [IMG_DEPTH];
    logic signed [15:0] kernel_mem [KER_DEPTH];
    logic signed [15:0] bias_mem   [OUT_CHANNELS];
    logic signed [31:0] gain_mem   [OUT_CHANNELS];
    logic signed [31:0] offset_mem [OUT_CHANNELS];
    logic signed [31:0] mean_mem   [OUT_CHANNELS];
    logic signed [31:0] var_mem    [OUT_CHANNELS];

    t_back_state r_state;
    t_back_state n_state;

    logic              start;
    logic              out_load;
    logic [OC_W-1:0]   head_oc;
    logic [IMG_AW-1:0] img_waddr;
    logic [KER_AW-1:0] ker_waddr;
    logic signed [15:0] load_q88;
    logic [1:0]        s;

    logic [OC_W-1:0]        r_oci;
    logic [2:0]             r_oc;
    logic [4:0]             r_row;
    logic [4:0]             r_col;
    logic                   r_issue;
    logic [IC_W-1:0]        r_ic;
    logic [K_W-1:0]         r_kr;
    logic [K_W-1:0]         r_kc;
    logic [KER_AW-1:0]      r_kaddr;
    logic signed [RC_W-1:0] r_base_r;
    logic signed [RC_W-1:0] r_base_c;
    logic [DIM_W-1:0]       r_h;
    logic [DIM_W-1:0]       r_w;
    logic                   r_v1;
    logic                   r_pad1;
    logic signed [15:0]     r_pix;
    logic signed [15:0]     r_wt;
    logic                   r_v2;
    logic signed [31:0]     r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [RC_W-1:0] ih;
    logic signed [RC_W-1:0] iw;
    logic                   inr;
    logic [IMG_AW-1:0]      img_raddr;
    logic                   last_tap;
    logic                   mac_done;

    logic                   norm_done;
    logic [30:0]            norm_inv;

    logic signed [15:0]  r_conv;
    logic signed [63:0]  r_p1;
    logic signed [31:0]  r_scale;
    logic signed [63:0]  r_p2;
    logic signed [47:0]  r_p3;
    logic signed [31:0]  r_shift;
    logic signed [31:0]  r_y1;
    logic signed [31:0]  y2;
    logic signed [15:0]  y3;

    logic                r_out_valid;
    logic [14:0]         r_res_value;
    logic [2:0]          r_res_chan;
    logic [4:0]          r_res_row;
    logic [4:0]          r_res_col;

    // load decode
    always_comb begin
        head_oc   = OC_W'(i_head.out_chan);
        load_q88  = sat16(64'(i_head.load_value));
        img_waddr = IMG_AW'((int'(i_head.in_chan) * MAX_HEIGHT + int'(i_head.row_index))
                            * MAX_WIDTH + int'(i_head.col_index));
        ker_waddr = KER_AW'(((int'(i_head.out_chan) * IN_CHANNELS + int'(i_head.in_chan))
                             * KERNEL_SIZE + int'(i_head.tap_row)) * KERNEL_SIZE
                            + int'(i_head.tap_col));
        s         = eff_stride(i_cfg.stride_step);
    end

    // tap walk addressing
    always_comb begin
        ih        = r_base_r + RC_W'(r_kr);
        iw        = r_base_c + RC_W'(r_kc);
        inr       = !ih[RC_W-1] && !iw[RC_W-1]
                    && (ih[DIM_W-1:0] < r_h) && (iw[DIM_W-1:0] < r_w);
        img_raddr = IMG_AW'((int'(r_ic) * MAX_HEIGHT + int'(ih[DIM_W-1:0])) * MAX_WIDTH
                            + int'(iw[DIM_W-1:0]));
        last_tap  = (r_ic == IC_W'(IN_CHANNELS - 1)) && (r_kr == K_W'(KERNEL_SIZE - 1))
                    && (r_kc == K_W'(KERNEL_SIZE - 1));
        mac_done  = !r_issue && !r_v1 && !r_v2;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (start) n_state = BK_CONV;
            BK_CONV:  if (mac_done && norm_done) n_state = BK_GAIN;
            BK_GAIN:  n_state = BK_SCALE;
            BK_SCALE: n_state = BK_MIX;
            BK_MIX:   n_state = BK_SHIFT;
            BK_SHIFT: n_state = BK_OUT;
            BK_OUT:   if (out_load) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop    = (r_state == BK_IDLE) && !i_q_stat.empty;
        start    = o_pop && (i_head.cmd == CMD_COMPUTE);
        out_load = (r_state == BK_OUT) && (!r_out_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.cmd == CMD_PIXEL) begin
            image_mem[img_waddr] <= load_q88;
        end
        r_pix <= image_mem[img_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.cmd == CMD_WEIGHT) begin
            kernel_mem[ker_waddr] <= load_q88;
        end
        r_wt <= kernel_mem[r_kaddr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            case (i_head.cmd)
                CMD_BIAS:     bias_mem[head_oc]   <= load_q88;
                CMD_GAMMA:    gain_mem[head_oc]   <= i_head.load_value;
                CMD_BETA:     offset_mem[head_oc] <= i_head.load_value;
                CMD_MEAN:     mean_mem[head_oc]   <= i_head.load_value;
                CMD_VARIANCE: var_mem[head_oc]    <= i_head.load_value;
                default: ;
            endcase
        end
    end

    // multiply-accumulate walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_v1 <= r_issue;
            r_v2 <= r_v1;
            if (start) begin
                r_issue <= 1'b1;
            end else if (r_issue && last_tap) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pad1 <= !inr;
        r_prod <= r_pad1 ? 32'sd0 : 32'(r_pix * r_wt);
        if (start) begin
            r_oci    <= head_oc;
            r_oc     <= i_head.out_chan;
            r_row    <= i_head.row_index;
            r_col    <= i_head.col_index;
            r_ic     <= '0;
            r_kr     <= '0;
            r_kc     <= '0;
            r_kaddr  <= KER_AW'(int'(i_head.out_chan) * TAPS);
            r_base_r <= RC_W'(RC_W'(i_head.row_index) * RC_W'(s)) - RC_W'(i_cfg.pad_amount);
            r_base_c <= RC_W'(RC_W'(i_head.col_index) * RC_W'(s)) - RC_W'(i_cfg.pad_amount);
            r_h      <= clamp_dim(i_cfg.image_height, MAX_HEIGHT);
            r_w      <= clamp_dim(i_cfg.image_width, MAX_WIDTH);
            r_acc    <= ACC_W'($signed({bias_mem[head_oc], 8'h00}));
        end else begin
            if (r_issue) begin
                r_kaddr <= r_kaddr + 1'b1;
                if (r_kc == K_W'(KERNEL_SIZE - 1)) begin
                    r_kc <= '0;
                    if (r_kr == K_W'(KERNEL_SIZE - 1)) begin
                        r_kr <= '0;
                        r_ic <= r_ic + 1'b1;
                    end else begin
                        r_kr <= r_kr + 1'b1;
                    end
                end else begin
                    r_kc <= r_kc + 1'b1;
                end
            end
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    cbr_norm u_norm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_variance (var_mem[head_oc]),
        .i_epsilon  (i_cfg.norm_epsilon),
        .o_done     (norm_done),
        .o_inv      (norm_inv)
    );

    // scale, shift and activation
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_GAIN: begin
                r_p1   <= gain_mem[r_oci] * $signed({1'b0, norm_inv});
                r_conv <= sat16(64'(r_acc >>> 8));
            end
            BK_SCALE: r_scale <= sat32(r_p1 >>> 16);
            BK_MIX: begin
                r_p2 <= r_scale * mean_mem[r_oci];
                r_p3 <= r_scale * r_conv;
            end
            BK_SHIFT: begin
                r_shift <= sat32(64'(offset_mem[r_oci]) - 64'(sat32(r_p2 >>> 16)));
                r_y1    <= sat32(64'(r_p3 >>> 8));
            end
            default: ;
        endcase
    end

    always_comb begin
        y2 = sat32(64'(r_y1) + 64'(r_shift));
        y3 = sat16(64'(y2 >>> 8));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res_value <= y3[15] ? 15'd0 : y3[14:0];
            r_res_chan  <= r_oc;
            r_res_row   <= r_row;
            r_res_col   <= r_col;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_res_value;
    assign o_result_chan  = r_res_chan;
    assign o_result_row   = r_res_row;
    assign o_result_col   = r_res_col;

endmodule
